// ----- rtl/rmq_pkg.sv -----
// Shared widths, types and constants for the rotation matrix to quaternion unit.
// No dependencies; every rtl file imports this package.
package rmq_pkg;

   // Number format
   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = 18;
   localparam int TOL_W     = 16;
   localparam int TOL_RESET = 7;

   // Radicand t (positive part) and the shifted radicand fed to the root
   localparam int T_W = ((FIELD_W > FRAC_BITS + 1) ? FIELD_W : FRAC_BITS + 1) + 2;
   localparam int N_W = T_W + FRAC_BITS - 2;
   // Half root width and root remainder width
   localparam int H_W = (N_W + 1) / 2;
   localparam int S_W = 2 * H_W + 1;

   // Quotient path: numerator is a sum of two entries
   localparam int D_W   = FIELD_W + 1;
   localparam int NUM_W = D_W + FRAC_BITS;
   localparam int DEN_W = H_W + 2;
   localparam int Q_W   = FIELD_W;
   localparam int R_W   = (NUM_W > DEN_W + Q_W - 1) ? NUM_W : DEN_W + Q_W - 1;
   localparam int MAX_W = (H_W > FIELD_W) ? H_W : FIELD_W;

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
   localparam logic signed [FIELD_W-1:0] W_IDENT =
      (FRAC_BITS >= FIELD_W - 1) ? FIELD_MAX : (FIELD_W'(1) << FRAC_BITS);
   localparam logic signed [T_W:0] ONE_T = (T_W + 1)'(1) << FRAC_BITS;

   // Which quaternion component carries the half root
   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2,
      COMP_W = 2'd3
   } comp_type;

   typedef logic signed [FIELD_W-1:0] ent_type;
   typedef logic signed [D_W-1:0]     num_type;

   // Front end result: radicand and the three quotient numerators
   typedef struct packed {
      logic                 deg;
      comp_type             root;
      logic signed [T_W:0]  t;
      num_type [2:0]        num;
   } front_type;

   // Context carried through the root pipeline
   typedef struct packed {
      logic          deg;
      comp_type      root;
      num_type [2:0] num;
   } ctx_type;

   // Per-slot quotient status out of the divider pipeline
   typedef struct packed {
      logic           ovf;
      logic           neg;
      logic [Q_W-1:0] quo;
   } quo_type;

   typedef struct packed {
      logic            deg;
      comp_type        root;
      logic            hzero;
      logic [H_W-1:0]  h;
      quo_type [2:0]   slot;
   } div_type;

endpackage

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// Rotation matrix (Q2.16) to unit quaternion, Shepperd's method, fully pipelined.
// Pipeline: 2 front stages + H_W root stages + Q_W+1 divider stages + 1 output
// register. Throughput: one item per cycle while no result waits stalled.
// The whole pipeline holds while a result waits stalled at the output.
// Synchronous reset empties the pipeline and sets the zero tolerance to 7.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div.
module rotation_matrix_to_quaternion_unit
   import rmq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [TOL_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [17:0] req_m00,
   input  logic signed [17:0] req_m01,
   input  logic signed [17:0] req_m02,
   input  logic signed [17:0] req_m10,
   input  logic signed [17:0] req_m11,
   input  logic signed [17:0] req_m12,
   input  logic signed [17:0] req_m20,
   input  logic signed [17:0] req_m21,
   input  logic signed [17:0] req_m22,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_quat_x,
   output logic signed [17:0] rsp_quat_y,
   output logic signed [17:0] rsp_quat_z,
   output logic signed [17:0] rsp_quat_w,
   output logic               rsp_degenerate
);

   logic [TOL_W-1:0] tol_ff;
   logic             adv;
   ent_type          mat [9];

   logic           fr_vld;
   front_type      fr;
   logic           sq_vld;
   logic [H_W-1:0] sq_h;
   ctx_type        sq_ctx;
   logic           dv_vld;
   div_type        dv;

   logic                      rsp_valid_ff;
   logic signed [FIELD_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic                      deg_ff;
   logic signed [FIELD_W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic signed [FIELD_W-1:0] s_sat [3];
   logic signed [FIELD_W-1:0] h_sat;

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(TOL_RESET);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // Pipeline advances unless a result sits stalled at the output
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign mat[0] = req_m00;
   assign mat[1] = req_m01;
   assign mat[2] = req_m02;
   assign mat[3] = req_m10;
   assign mat[4] = req_m11;
   assign mat[5] = req_m12;
   assign mat[6] = req_m20;
   assign mat[7] = req_m21;
   assign mat[8] = req_m22;

   rmq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .vld_in_i (req_valid),
      .mat      (mat),
      .tol      (tol_ff),
      .vld_o    (fr_vld),
      .fr_o     (fr)
   );

   rmq_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .vld_i (fr_vld),
      .fr_i  (fr),
      .vld_o (sq_vld),
      .h_o   (sq_h),
      .ctx_o (sq_ctx)
   );

   rmq_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .vld_i (sq_vld),
      .h_i   (sq_h),
      .ctx_i (sq_ctx),
      .vld_o (dv_vld),
      .res_o (dv)
   );

   // Saturate quotients and the half root
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dv.hzero) begin
            s_sat[k] = '0;
         end else if (dv.slot[k].ovf) begin
            s_sat[k] = dv.slot[k].neg ? FIELD_MIN : FIELD_MAX;
         end else if (dv.slot[k].neg) begin
            s_sat[k] = (dv.slot[k].quo > Q_W'(FIELD_MIN)) ? FIELD_MIN
                                                          : FIELD_W'(-dv.slot[k].quo);
         end else begin
            s_sat[k] = (dv.slot[k].quo > Q_W'(FIELD_MAX)) ? FIELD_MAX
                                                          : FIELD_W'(dv.slot[k].quo);
         end
      end
      h_sat = (MAX_W'(dv.h) > MAX_W'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(dv.h);
   end

   // Place the half root and quotients into x, y, z, w
   always_comb begin
      qx_in = s_sat[0];
      qy_in = s_sat[1];
      qz_in = s_sat[2];
      qw_in = h_sat;
      case (dv.root)
         COMP_X: begin
            qx_in = h_sat;    qw_in = s_sat[0];
            qy_in = s_sat[1]; qz_in = s_sat[2];
         end
         COMP_Y: begin
            qy_in = h_sat;    qw_in = s_sat[0];
            qz_in = s_sat[1]; qx_in = s_sat[2];
         end
         COMP_Z: begin
            qz_in = h_sat;    qw_in = s_sat[0];
            qx_in = s_sat[1]; qy_in = s_sat[2];
         end
         default: begin
            qx_in = s_sat[0]; qy_in = s_sat[1];
            qz_in = s_sat[2]; qw_in = h_sat;
         end
      endcase
      if (dv.deg) begin
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
         qw_in = W_IDENT;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         qz_ff  <= qz_in;
         qw_ff  <= qw_in;
         deg_ff <= dv.deg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_x     = qx_ff;
   assign rsp_quat_y     = qy_ff;
   assign rsp_quat_z     = qz_ff;
   assign rsp_quat_w     = qw_ff;
   assign rsp_degenerate = deg_ff;

endmodule

// ----- rtl/rmq_front.sv -----
// Front end: zero-row test, trace sign, pivot choice, radicand and numerators.
// Two register stages; depends on rmq_pkg.
module rmq_front
   import rmq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             vld_in_i,
   input  ent_type          mat [9],
   input  logic [TOL_W-1:0] tol,
   output logic             vld_o,
   output front_type        fr_o
);

   logic              vld_a_ff;
   logic              deg_a_ff;
   logic              pos_a_ff;
   comp_type          piv_a_ff;
   ent_type           mat_a_ff [9];
   logic              vld_b_ff;
   front_type         fr_b_ff;

   logic [FIELD_W-1:0]       mag [9];
   logic [2:0]               row_zero;
   logic signed [FIELD_W+1:0] tr;
   logic                     deg_in;
   logic                     pos_in;
   comp_type                 piv_in;
   front_type                fr_in;

   // Stage A: row magnitudes, trace and pivot
   always_comb begin
      for (int e = 0; e < 9; e++) begin
         mag[e] = mat[e][FIELD_W-1] ? FIELD_W'(-mat[e]) : FIELD_W'(mat[e]);
      end
      for (int r = 0; r < 3; r++) begin
         row_zero[r] = (mag[3*r] <= FIELD_W'(tol)) && (mag[3*r+1] <= FIELD_W'(tol))
                       && (mag[3*r+2] <= FIELD_W'(tol));
      end
      deg_in = |row_zero;
      tr = (FIELD_W+2)'(mat[0]) + (FIELD_W+2)'(mat[4]) + (FIELD_W+2)'(mat[8]);
      pos_in = (tr > 0);
      piv_in = COMP_X;
      if (mat[4] > mat[0]) piv_in = COMP_Y;
      if (mat[8] > ((piv_in == COMP_Y) ? mat[4] : mat[0])) piv_in = COMP_Z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= vld_in_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         deg_a_ff <= deg_in;
         pos_a_ff <= pos_in;
         piv_a_ff <= piv_in;
         mat_a_ff <= mat;
      end
   end

   // Stage B: radicand and numerators for the selected case
   always_comb begin
      fr_in.deg = deg_a_ff;
      if (pos_a_ff) begin
         fr_in.root   = COMP_W;
         fr_in.t      = (T_W+1)'(mat_a_ff[0]) + (T_W+1)'(mat_a_ff[4])
                        + (T_W+1)'(mat_a_ff[8]) + ONE_T;
         fr_in.num[0] = D_W'(mat_a_ff[5]) - D_W'(mat_a_ff[7]);
         fr_in.num[1] = D_W'(mat_a_ff[6]) - D_W'(mat_a_ff[2]);
         fr_in.num[2] = D_W'(mat_a_ff[1]) - D_W'(mat_a_ff[3]);
      end else begin
         case (piv_a_ff)
            COMP_Y: begin
               fr_in.root   = COMP_Y;
               fr_in.t      = (T_W+1)'(mat_a_ff[4]) - (T_W+1)'(mat_a_ff[8])
                              - (T_W+1)'(mat_a_ff[0]) + ONE_T;
               fr_in.num[0] = D_W'(mat_a_ff[6]) - D_W'(mat_a_ff[2]);
               fr_in.num[1] = D_W'(mat_a_ff[5]) + D_W'(mat_a_ff[7]);
               fr_in.num[2] = D_W'(mat_a_ff[3]) + D_W'(mat_a_ff[1]);
            end
            COMP_Z: begin
               fr_in.root   = COMP_Z;
               fr_in.t      = (T_W+1)'(mat_a_ff[8]) - (T_W+1)'(mat_a_ff[0])
                              - (T_W+1)'(mat_a_ff[4]) + ONE_T;
               fr_in.num[0] = D_W'(mat_a_ff[1]) - D_W'(mat_a_ff[3]);
               fr_in.num[1] = D_W'(mat_a_ff[6]) + D_W'(mat_a_ff[2]);
               fr_in.num[2] = D_W'(mat_a_ff[7]) + D_W'(mat_a_ff[5]);
            end
            default: begin
               fr_in.root   = COMP_X;
               fr_in.t      = (T_W+1)'(mat_a_ff[0]) - (T_W+1)'(mat_a_ff[4])
                              - (T_W+1)'(mat_a_ff[8]) + ONE_T;
               fr_in.num[0] = D_W'(mat_a_ff[5]) - D_W'(mat_a_ff[7]);
               fr_in.num[1] = D_W'(mat_a_ff[1]) + D_W'(mat_a_ff[3]);
               fr_in.num[2] = D_W'(mat_a_ff[2]) + D_W'(mat_a_ff[6]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (adv) begin
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr_b_ff <= fr_in;
      end
   end

   assign vld_o = vld_b_ff;
   assign fr_o  = fr_b_ff;

endmodule

// ----- rtl/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, giving the half root.
// Carries the item context alongside; depends on rmq_pkg.
module rmq_sqrt
   import rmq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           vld_i,
   input  front_type      fr_i,
   output logic           vld_o,
   output logic [H_W-1:0] h_o,
   output ctx_type        ctx_o
);

   logic [S_W-1:0] rem_ff  [H_W];
   logic [H_W-1:0] root_ff [H_W];
   ctx_type        ctx_ff  [H_W];
   logic           vld_ff  [H_W];

   logic [S_W-1:0] n_in;
   ctx_type        ctx_in;

   // Radicand scaled so the root lands at half scale; non-positive gives zero
   always_comb begin
      if (fr_i.t > 0) begin
         n_in = S_W'(fr_i.t[T_W-1:0]) << (FRAC_BITS - 2);
      end else begin
         n_in = '0;
      end
      ctx_in.deg  = fr_i.deg;
      ctx_in.root = fr_i.root;
      ctx_in.num  = fr_i.num;
   end

   for (genvar s = 0; s < H_W; s++) begin : g_stage
      localparam int B = H_W - 1 - s;
      logic [S_W-1:0] rem_prev;
      logic [S_W-1:0] trial;
      logic [H_W-1:0] root_prev;
      ctx_type        ctx_prev;
      logic           vld_prev;

      if (s == 0) begin : g_first
         assign rem_prev  = n_in;
         assign root_prev = '0;
         assign ctx_prev  = ctx_in;
         assign vld_prev  = vld_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign ctx_prev  = ctx_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial = (S_W'(root_prev) << (B + 1)) + (S_W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem_prev >= trial) begin
               rem_ff[s]  <= rem_prev - trial;
               root_ff[s] <= root_prev | (H_W'(1) << B);
            end else begin
               rem_ff[s]  <= rem_prev;
               root_ff[s] <= root_prev;
            end
            ctx_ff[s] <= ctx_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_prev;
         end
      end
   end

   assign vld_o = vld_ff[H_W-1];
   assign h_o   = root_ff[H_W-1];
   assign ctx_o = ctx_ff[H_W-1];

endmodule

// ----- rtl/rmq_div.sv -----
// Pipelined restoring divider for three quotients |d| * 2^FRAC_BITS / (4h).
// One overflow stage, then one quotient bit per stage; depends on rmq_pkg.
module rmq_div
   import rmq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           vld_i,
   input  logic [H_W-1:0] h_i,
   input  ctx_type        ctx_i,
   output logic           vld_o,
   output div_type        res_o
);

   localparam int NS = Q_W + 1;

   logic [R_W-1:0]   rem_ff [NS][3];
   logic [DEN_W-1:0] den_ff [NS];
   div_type          res_ff [NS];
   logic             vld_ff [NS];

   logic [R_W-1:0]   rem0_in [3];
   logic [DEN_W-1:0] den_in;
   div_type          res0_in;

   // Setup stage: magnitudes, divisor and quotient overflow
   always_comb begin
      den_in        = DEN_W'(h_i) << 2;
      res0_in.deg   = ctx_i.deg;
      res0_in.root  = ctx_i.root;
      res0_in.hzero = (h_i == '0);
      res0_in.h     = h_i;
      for (int k = 0; k < 3; k++) begin
         // magnitude is unsigned; the most negative sum needs the top bit
         rem0_in[k] = R_W'($unsigned(ctx_i.num[k][D_W-1] ? D_W'(-ctx_i.num[k])
                                                          : D_W'(ctx_i.num[k])))
                      << FRAC_BITS;
         res0_in.slot[k].neg = ctx_i.num[k][D_W-1];
         res0_in.slot[k].ovf = (rem0_in[k] >> Q_W) >= R_W'(den_in);
         res0_in.slot[k].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem0_in;
         den_ff[0] <= den_in;
         res_ff[0] <= res0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= vld_i;
      end
   end

   // Quotient bit stages, most significant first
   for (genvar s = 1; s < NS; s++) begin : g_stage
      localparam int B = Q_W - s;
      logic [R_W-1:0] cand;
      logic [R_W-1:0] rem_in [3];
      div_type        res_in;

      assign cand = R_W'(den_ff[s-1]) << B;

      always_comb begin
         res_in = res_ff[s-1];
         for (int k = 0; k < 3; k++) begin
            if (rem_ff[s-1][k] >= cand) begin
               rem_in[k] = rem_ff[s-1][k] - cand;
               res_in.slot[k].quo[B] = 1'b1;
            end else begin
               rem_in[k] = rem_ff[s-1][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_ff[s-1];
            res_ff[s] <= res_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   assign vld_o = vld_ff[NS-1];
   assign res_o = res_ff[NS-1];

endmodule

// ----- rtl/rmq_checker.sv -----
// Port-level checks for the rotation matrix to quaternion unit, bound to the top.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_unit.
module rmq_props
   import rmq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [17:0] rsp_quat_x,
   input logic signed [17:0] rsp_quat_y,
   input logic signed [17:0] rsp_quat_z,
   input logic signed [17:0] rsp_quat_w,
   input logic               rsp_degenerate
);

   // A degenerate item is always the identity
   a_deg_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0 && rsp_quat_w == W_IDENT)
      else $error("degenerate item is not identity");

   // Input is held back only while a result waits stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_y)
         && $stable(rsp_quat_z) && $stable(rsp_quat_w) && $stable(rsp_degenerate))
      else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_props u_rmq_props (.*);

// ----- test/rmq_checker.sv -----
// Checker for the rotation matrix to quaternion unit: watches both channels,
// predicts each quaternion from the accepted matrix and compares. Uses rmq_pkg.
`timescale 1ns / 1ps
module rmq_checker
   import rmq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [TOL_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [17:0] req_m00,
   input  logic signed [17:0] req_m01,
   input  logic signed [17:0] req_m02,
   input  logic signed [17:0] req_m10,
   input  logic signed [17:0] req_m11,
   input  logic signed [17:0] req_m12,
   input  logic signed [17:0] req_m20,
   input  logic signed [17:0] req_m21,
   input  logic signed [17:0] req_m22,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [17:0] rsp_quat_x,
   input  logic signed [17:0] rsp_quat_y,
   input  logic signed [17:0] rsp_quat_z,
   input  logic signed [17:0] rsp_quat_w,
   input  logic               rsp_degenerate,
   output int                 fail_count,
   output int                 pending_quats,
   output int                 degenerate_seen
);

   typedef struct {
      logic signed [17:0] qx, qy, qz, qw;
      logic               deg;
   } quat_type;

   quat_type       quat_queue[$];
   logic [15:0]    zero_tol;

   function automatic longint half_sqrt(longint t);
      longint n, r, b;
      if (t <= 0) return 0;
      n = t << (FRAC_BITS - 2);
      r = 0;
      b = longint'(1) << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint quot_over_4h(longint d, longint h);
      longint mag, q;
      if (h <= 0) return 0;
      mag = (d < 0) ? -d : d;
      q = (mag << FRAC_BITS) / (4 * h);
      return (d < 0) ? -q : q;
   endfunction

   function automatic logic signed [17:0] clamp18(longint v);
      if (v > 131071) return 18'sd131071;
      if (v < -131072) return -18'sd131072;
      return v[17:0];
   endfunction

   function automatic quat_type convert_matrix(longint m[3][3], logic [15:0] tol);
      quat_type res;
      longint q[4];
      longint one, tr, h, a;
      int     i, j, k;
      logic   deg, zr;
      one = longint'(1) << FRAC_BITS;
      deg = 0;
      for (int r = 0; r < 3; r++) begin
         zr = 1;
         for (int c = 0; c < 3; c++) begin
            a = (m[r][c] < 0) ? -m[r][c] : m[r][c];
            if (a > tol) zr = 0;
         end
         if (zr) deg = 1;
      end
      if (deg) begin
         q[0] = 0; q[1] = 0; q[2] = 0; q[3] = one;
      end else begin
         tr = m[0][0] + m[1][1] + m[2][2];
         if (tr > 0) begin
            h = half_sqrt(tr + one);
            q[3] = h;
            q[0] = quot_over_4h(m[1][2] - m[2][1], h);
            q[1] = quot_over_4h(m[2][0] - m[0][2], h);
            q[2] = quot_over_4h(m[0][1] - m[1][0], h);
         end else begin
            // pivot on the largest diagonal, ties keep the lower axis
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            h = half_sqrt(m[i][i] - m[j][j] - m[k][k] + one);
            q[i] = h;
            q[3] = quot_over_4h(m[j][k] - m[k][j], h);
            q[j] = quot_over_4h(m[i][j] + m[j][i], h);
            q[k] = quot_over_4h(m[i][k] + m[k][i], h);
         end
      end
      res.qx = clamp18(q[0]);
      res.qy = clamp18(q[1]);
      res.qz = clamp18(q[2]);
      res.qw = clamp18(q[3]);
      res.deg = deg;
      return res;
   endfunction

   // tolerance shadow, predict on input, compare on output
   always @(posedge clock) begin
      longint   m[3][3];
      quat_type want;
      if (reset) begin
         zero_tol <= 16'd7;
         quat_queue.delete();
         fail_count <= 0;
         degenerate_seen <= 0;
         pending_quats <= 0;
      end else begin
         if (csr_wr_en) zero_tol <= csr_wr_data;
         if (req_valid && !req_stall) begin
            m[0][0] = req_m00; m[0][1] = req_m01; m[0][2] = req_m02;
            m[1][0] = req_m10; m[1][1] = req_m11; m[1][2] = req_m12;
            m[2][0] = req_m20; m[2][1] = req_m21; m[2][2] = req_m22;
            quat_queue.push_back(convert_matrix(m, zero_tol));
         end
         if (rsp_valid && !rsp_stall) begin
            if (quat_queue.size() == 0) begin
               $error("quaternion with none expected");
               fail_count <= fail_count + 1;
            end else begin
               want = quat_queue.pop_front();
               if (rsp_degenerate) degenerate_seen <= degenerate_seen + 1;
               if (rsp_quat_x !== want.qx || rsp_quat_y !== want.qy ||
                   rsp_quat_z !== want.qz || rsp_quat_w !== want.qw ||
                   rsp_degenerate !== want.deg)
                  fail_count <= fail_count + 1;
               if (rsp_quat_x !== want.qx)
                  $error("quat_x expected %0d actual %0d", want.qx, rsp_quat_x);
               if (rsp_quat_y !== want.qy)
                  $error("quat_y expected %0d actual %0d", want.qy, rsp_quat_y);
               if (rsp_quat_z !== want.qz)
                  $error("quat_z expected %0d actual %0d", want.qz, rsp_quat_z);
               if (rsp_quat_w !== want.qw)
                  $error("quat_w expected %0d actual %0d", want.qw, rsp_quat_w);
               if (rsp_degenerate !== want.deg)
                  $error("degenerate expected %0d actual %0d", want.deg, rsp_degenerate);
            end
         end
         pending_quats <= quat_queue.size();
      end
   end

endmodule

// ----- test/rotation_matrix_to_quaternion_unit_tb.sv -----
// Top of the testbench: clock, reset, matrix stimulus, tolerance writes, verdict.
// Depends on rmq_pkg, rmq_checker and the rotation_matrix_to_quaternion_unit RTL.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_tb
   import rmq_pkg::*;
;

   localparam int LATENCY     = 39;
   localparam int MAX_CYCLE   = 400000;
   localparam int ONE_Q       = 65536;
   localparam int HOLD_CYCLES = 150;
   localparam int HOLD_AT     = 700;
   localparam logic signed [17:0] ONE_E = 18'sd65536;

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_wr_en = 0;
   logic [TOL_W-1:0]   csr_wr_data = '0;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [17:0] mat[9] = '{default: '0};
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [17:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic               rsp_degenerate;
   int                 fail_count, pending_quats, degenerate_seen;
   int                 cycle = 0;
   int                 sent = 0;
   bit                 busy_stretch = 0;
   bit                 hold_done = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   rotation_matrix_to_quaternion_unit dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_stall,
      .req_m00(mat[0]), .req_m01(mat[1]), .req_m02(mat[2]),
      .req_m10(mat[3]), .req_m11(mat[4]), .req_m12(mat[5]),
      .req_m20(mat[6]), .req_m21(mat[7]), .req_m22(mat[8]),
      .rsp_valid, .rsp_stall,
      .rsp_quat_x, .rsp_quat_y, .rsp_quat_z, .rsp_quat_w, .rsp_degenerate
   );

   rmq_checker u_checker (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_stall,
      .req_m00(mat[0]), .req_m01(mat[1]), .req_m02(mat[2]),
      .req_m10(mat[3]), .req_m11(mat[4]), .req_m12(mat[5]),
      .req_m20(mat[6]), .req_m21(mat[7]), .req_m22(mat[8]),
      .rsp_valid, .rsp_stall,
      .rsp_quat_x, .rsp_quat_y, .rsp_quat_z, .rsp_quat_w, .rsp_degenerate,
      .fail_count, .pending_quats, .degenerate_seen
   );

   // watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall, quiet stretches, and one long hold-off
   always @(posedge clock) begin
      int hold_cnt;
      if (!hold_done && sent >= HOLD_AT) begin
         hold_done <= 1;
         rsp_stall <= 1;
         for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clock);
      end
      rsp_stall <= busy_stretch ? 1'b0 : ($urandom_range(99) < 36);
   end

   function automatic logic signed [17:0] rand_entry(int mode);
      case (mode)
         0: return 18'($urandom);
         1: return 18'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
         default: return 18'(int'($urandom_range(40)) - 20);
      endcase
   endfunction

   // presents one matrix, waits until it is taken
   task automatic send_matrix(logic signed [17:0] e[9], bit gappy);
      while (gappy && !busy_stretch && $urandom_range(99) < 36) begin
         req_valid <= 0;
         @(posedge clock);
      end
      for (int n = 0; n < 9; n++) mat[n] <= e[n];
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // rotation about one axis, with random angle via a coarse table-free approach
   task automatic make_rotation(output logic signed [17:0] e[9]);
      int ax, c, s, sg;
      real ang;
      ang = $urandom_range(6283) / 1000.0;
      c = $rtoi($cos(ang) * ONE_Q);
      s = $rtoi($sin(ang) * ONE_Q);
      ax = $urandom_range(2);
      sg = $urandom_range(1) ? 1 : -1;
      for (int n = 0; n < 9; n++) e[n] = '0;
      case (ax)
         0: begin e[0] = ONE_E; e[4] = 18'(c); e[5] = 18'(-s); e[7] = 18'(s);
                  e[8] = 18'(c); end
         1: begin e[4] = ONE_E; e[0] = 18'(c); e[2] = 18'(s); e[6] = 18'(-s);
                  e[8] = 18'(c); end
         default: begin e[8] = ONE_E; e[0] = 18'(c); e[1] = 18'(-s); e[3] = 18'(s);
                        e[4] = 18'(c); end
      endcase
      // sign flips on two rows keep it orthonormal-ish but reach other pivots
      if (sg < 0) for (int n = 0; n < 6; n++) e[n] = -e[n];
      for (int n = 0; n < 9; n++) e[n] = e[n] + 18'(int'($urandom_range(6)) - 3);
   endtask

   task automatic wait_drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_quats != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tol(logic [15:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      logic signed [17:0] e[9];
      logic [15:0] tols[5];
      tols = '{16'd0, 16'd65535, 16'd7, 16'd300, 16'd20};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: identity, extremes, each pivot, zero rows, tolerance edges, then random fills
      for (int d = 0; d < 22; d++) begin
         for (int n = 0; n < 9; n++) e[n] = '0;
         case (d)
            0: begin e[0] = ONE_E; e[4] = ONE_E; e[8] = ONE_E; end
            1: for (int n = 0; n < 9; n++) e[n] = 18'sh1FFFF;
            2: for (int n = 0; n < 9; n++) e[n] = -18'sh20000;
            3: begin e[0] = ONE_E; e[4] = -ONE_E; e[8] = -ONE_E; end
            4: begin e[0] = -ONE_E; e[4] = ONE_E; e[8] = -ONE_E; end
            5: begin e[0] = -ONE_E; e[4] = -ONE_E; e[8] = ONE_E; end
            6: begin e[0] = -ONE_E; e[4] = -ONE_E; e[8] = -ONE_E; end
            7: begin e[0] = ONE_E; e[4] = ONE_E; end
            8: begin e[0] = 18'sd7; e[1] = -18'sd7; e[2] = 18'sd7; e[4] = ONE_E;
                     e[8] = ONE_E; end
            9: begin e[0] = 18'sd8; e[1] = -18'sd7; e[2] = 18'sd7; e[4] = ONE_E;
                     e[8] = ONE_E; end
            10: begin e[0] = -18'sd20; e[4] = -18'sd20; e[8] = -18'sd20; e[1] = 18'sd9;
                      e[5] = 18'sd9; e[6] = 18'sd9; end
            11: begin e[0] = 18'sh1FFFF; e[1] = -18'sh20000; e[3] = 18'sh1FFFF;
                      e[4] = -ONE_E; e[8] = -ONE_E; end
            12: begin e[5] = 18'sh1FFFF; e[7] = -18'sh20000; e[0] = 18'sd1; e[4] = 18'sd1;
                      e[8] = 18'sd1; e[1] = 18'sd9; e[6] = 18'sd9; e[3] = 18'sd9; end
            default: for (int n = 0; n < 9; n++) e[n] = rand_entry(d % 3);
         endcase
         send_matrix(e, 0);
      end
      wait_drain();

      // random phases over several tolerance settings
      for (int ph = 0; ph < 5; ph++) begin
         write_tol(tols[ph]);
         if (ph == 3) busy_stretch <= 1;
         for (int it = 0; it < 250; it++) begin
            if ($urandom_range(99) < 70) make_rotation(e);
            else for (int n = 0; n < 9; n++) e[n] = rand_entry($urandom_range(2));
            send_matrix(e, 1);
         end
         busy_stretch <= 0;
         wait_drain();
      end

      $display("Converted %0d matrices over five tolerance settings, %0d degenerate.",
               sent, degenerate_seen);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
